// ===== hw/rtl/stc_pkg.sv =====
// Shared types and constants for the stopwatch / countdown timer core.
// Holds action and mode codes, item and result layouts, and stream field offsets.
// No dependencies.
package stc_pkg;

    // action codes carried in the slave-side tuser
    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_START     = 3'd1;
    localparam logic [2:0] ACT_STOP      = 3'd2;
    localparam logic [2:0] ACT_PRECISION = 3'd3;
    localparam logic [2:0] ACT_ENCODER   = 3'd4;

    typedef enum logic [1:0] {
        MODE_SELECT  = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_PAUSED  = 2'd2,
        MODE_STOPPED = 2'd3
    } t_mode;

    localparam int unsigned ALARM_MAX  = 5999;
    localparam int unsigned BEEP_AFTER = 50;
    // ceil(2^31 / 15): exact quotient for values below 2^27
    localparam logic [27:0] RECIP_15   = 28'd143165577;

    // stream widths
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 40;

    // master-side tdata bit positions
    localparam int unsigned OUT_MODE_LO  = 0;
    localparam int unsigned OUT_TIME_LO  = 2;
    localparam int unsigned OUT_DOT      = 34;
    localparam int unsigned OUT_BLANK    = 35;
    localparam int unsigned OUT_REFRESH  = 36;
    localparam int unsigned OUT_SBEEP    = 37;
    localparam int unsigned OUT_LBEEP    = 38;
    localparam int unsigned OUT_ENCCLR   = 39;

    typedef struct packed {
        logic [2:0]  action;
        logic [30:0] quarter_count;
        logic        half_second_flag;
        logic        quarter_second_flag;
        logic        whole_second_flag;
        logic [15:0] encoder_count;
    } t_item;

    typedef struct packed {
        t_mode       current_mode;
        logic [31:0] time_to_show;
        logic        dot_on;
        logic        display_blank;
        logic        display_refresh;
        logic        short_beep;
        logic        long_beep;
        logic        encoder_clear;
    } t_result;

endpackage

// ===== hw/rtl/stc_in_stage.sv =====
// Input register for the timer core: holds one accepted item for the engine.
// Depends on stc_pkg (t_item).
module stc_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  stc_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output stc_pkg::t_item o_item
);

    logic           r_valid;
    stc_pkg::t_item r_item;

    // refill in the same cycle the engine consumes the held item
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hw/rtl/stc_engine.sv =====
// Timer state and the single-pass update for one item.
// Depends on stc_pkg (codes, t_item, t_result, constants).
module stc_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  stc_pkg::t_item   i_item,
    output stc_pkg::t_result o_result
);

    stc_pkg::t_mode     r_mode,    n_mode;
    logic               r_blink,   n_blink;
    logic signed [30:0] r_elapsed, n_elapsed;
    logic [31:0]        r_start,   n_start;
    logic [30:0]        r_pause,   n_pause;
    logic               r_dot,     n_dot;
    logic [1:0]         r_step,    n_step;
    logic signed [22:0] r_last,    n_last;
    logic [12:0]        r_alarm,   n_alarm;

    logic [31:0]        diff;
    logic [31:0]        mag;
    logic signed [30:0] elapsed_run;
    logic [26:0]        sec_div4;
    logic [54:0]        prod;
    logic [23:0]        quot15;
    logic [27:0]        quot15_x15;
    logic [3:0]         rem15;
    logic [5:0]         rem60;
    logic               beep_window;
    logic signed [22:0] enc_x;
    logic signed [22:0] scaled;
    logic signed [24:0] alarm_try;
    logic               refresh, sbeep, lbeep, clear;
    logic               full_reset;
    stc_pkg::t_mode     blank_mode;
    logic signed [31:0] elapsed_w;

    // elapsed seconds from quarter count, rounded toward zero
    always_comb begin
        diff        = {1'b0, i_item.quarter_count} - r_start;
        mag         = (~diff) + 32'd1;
        elapsed_run = diff[31] ? -$signed({1'b0, mag[31:2]})
                               : $signed({2'b00, diff[30:2]});
    end

    // seconds mod 60 = 4 * ((sec / 4) mod 15) + sec mod 4
    always_comb begin
        sec_div4    = diff[30:4];
        prod        = sec_div4 * stc_pkg::RECIP_15;
        quot15      = prod[54:31];
        quot15_x15  = {quot15, 4'd0} - {4'd0, quot15};
        rem15       = 4'(({1'b0, sec_div4}) - quot15_x15);
        rem60       = {rem15, diff[3:2]};
        beep_window = !diff[31] && (diff[30:2] != 29'd0)
                      && (rem60 > 6'(stc_pkg::BEEP_AFTER));
    end

    always_comb begin
        enc_x = 23'($signed(i_item.encoder_count));
        case (r_step)
            2'd0:    scaled = (enc_x <<< 6) - (enc_x <<< 2);
            2'd1:    scaled = (enc_x <<< 3) + (enc_x <<< 1);
            default: scaled = enc_x;
        endcase
        alarm_try = $signed({12'd0, r_alarm}) + 25'(scaled) - 25'(r_last);
    end

    always_comb begin
        n_mode     = r_mode;
        n_blink    = r_blink;
        n_elapsed  = r_elapsed;
        n_start    = r_start;
        n_pause    = r_pause;
        n_dot      = r_dot;
        n_step     = r_step;
        n_last     = r_last;
        n_alarm    = r_alarm;
        refresh    = 1'b0;
        sbeep      = 1'b0;
        lbeep      = 1'b0;
        clear      = 1'b0;
        full_reset = 1'b0;
        blank_mode = r_mode;

        unique case (i_item.action)
            stc_pkg::ACT_TICK: begin
                if (r_mode == stc_pkg::MODE_RUNNING) begin
                    n_elapsed = elapsed_run;
                    if (i_item.half_second_flag) begin
                        n_dot = !r_dot;
                    end
                    sbeep = beep_window && i_item.whole_second_flag;
                    if (r_alarm != 13'd0 && elapsed_run >= $signed({18'd0, r_alarm})) begin
                        n_mode = stc_pkg::MODE_STOPPED;
                        lbeep  = 1'b1;
                    end
                end else begin
                    n_dot = 1'b1;
                end
                if (r_mode == stc_pkg::MODE_STOPPED && i_item.half_second_flag) begin
                    n_blink = !r_blink;
                end
                refresh = i_item.quarter_second_flag;
            end
            stc_pkg::ACT_START: begin
                unique case (r_mode)
                    stc_pkg::MODE_SELECT: begin
                        n_mode    = stc_pkg::MODE_RUNNING;
                        n_elapsed = '0;
                        n_pause   = '0;
                        n_start   = {1'b0, i_item.quarter_count};
                    end
                    stc_pkg::MODE_RUNNING: begin
                        n_mode  = stc_pkg::MODE_PAUSED;
                        n_pause = i_item.quarter_count;
                    end
                    stc_pkg::MODE_PAUSED: begin
                        n_mode  = stc_pkg::MODE_RUNNING;
                        n_start = r_start + {1'b0, i_item.quarter_count} - {1'b0, r_pause};
                    end
                    default: full_reset = 1'b1;
                endcase
            end
            stc_pkg::ACT_STOP: begin
                if (r_mode == stc_pkg::MODE_RUNNING || r_mode == stc_pkg::MODE_PAUSED) begin
                    n_mode = stc_pkg::MODE_STOPPED;
                end else begin
                    full_reset = 1'b1;
                end
            end
            stc_pkg::ACT_PRECISION: begin
                if (r_mode == stc_pkg::MODE_SELECT) begin
                    n_step = (r_step >= 2'd2) ? 2'd0 : r_step + 2'd1;
                    n_last = '0;
                    clear  = 1'b1;
                end else if (r_mode == stc_pkg::MODE_STOPPED) begin
                    full_reset = 1'b1;
                end
            end
            stc_pkg::ACT_ENCODER: begin
                if (scaled != r_last) begin
                    if (r_mode == stc_pkg::MODE_STOPPED) begin
                        full_reset = 1'b1;
                    end else if (r_mode == stc_pkg::MODE_SELECT) begin
                        n_last  = scaled;
                        n_dot   = 1'b1;
                        refresh = 1'b1;
                        if (alarm_try < 0) begin
                            n_alarm = '0;
                        end else if (alarm_try > 25'(stc_pkg::ALARM_MAX)) begin
                            n_alarm = 13'(stc_pkg::ALARM_MAX);
                        end else begin
                            n_alarm = alarm_try[12:0];
                        end
                    end
                end
            end
            default: ;
        endcase

        if (full_reset) begin
            n_mode    = stc_pkg::MODE_SELECT;
            n_elapsed = '0;
            n_start   = '0;
            n_pause   = '0;
            n_step    = '0;
            n_last    = '0;
            n_alarm   = '0;
            clear     = 1'b1;
        end
        // a tick takes the display before its own alarm stop
        if (i_item.action != stc_pkg::ACT_TICK) begin
            blank_mode = n_mode;
        end
    end

    always_comb begin
        elapsed_w                = 32'(n_elapsed);
        o_result.current_mode    = n_mode;
        o_result.time_to_show    = (n_alarm == 13'd0) ? elapsed_w
                                   : {19'd0, n_alarm} - elapsed_w;
        o_result.dot_on          = n_dot;
        o_result.display_blank   = n_blink && (blank_mode == stc_pkg::MODE_STOPPED);
        o_result.display_refresh = refresh;
        o_result.short_beep      = sbeep;
        o_result.long_beep       = lbeep;
        o_result.encoder_clear   = clear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= stc_pkg::MODE_SELECT;
            r_blink   <= 1'b0;
            r_elapsed <= '0;
            r_start   <= '0;
            r_pause   <= '0;
            r_dot     <= 1'b1;
            r_step    <= '0;
            r_last    <= '0;
            r_alarm   <= '0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_blink   <= n_blink;
            r_elapsed <= n_elapsed;
            r_start   <= n_start;
            r_pause   <= n_pause;
            r_dot     <= n_dot;
            r_step    <= n_step;
            r_last    <= n_last;
            r_alarm   <= n_alarm;
        end
    end

endmodule

// ===== hw/rtl/stc_out_stage.sv =====
// Result register for the timer core: holds one result item until taken.
// Depends on stc_pkg (t_result).
module stc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  stc_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output stc_pkg::t_result o_result
);

    logic             r_valid;
    stc_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== hw/rtl/stopwatch_countdown_timer_core.sv =====
// Top level of the stopwatch / countdown timer core.
// Depends on stc_pkg, stc_in_stage, stc_engine and stc_out_stage.
//
//  channel   | dir | handshake                        | payload
//  ----------+-----+----------------------------------+------------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready | tdata 56b, tuser 3b (action)
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready | tdata 40b
//
//  Flow: one item per clock sustained while the master side takes results; the input
//  register loads at the accepting edge and the result register when the engine
//  processes the held item, which waits while the master side holds a stalled result.
//  The update of the timer state is one pass of logic between the two registers,
//  so consecutive items see each other's state without bubbles.
//  Reset: synchronous, active low; clears both stage valids and the timer state
//  (select mode, dot on, no alarm).
//  Stalls: a stalled master side holds its result; the input register takes one more
//  item only while it is empty, then s_axis backs up.
module stopwatch_countdown_timer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [30:0] quarter_count, [31] half_second_flag, [32] quarter_second_flag,
    // [33] whole_second_flag, [49:34] encoder_count, [55:50] zero
    input  logic [55:0] i_s_axis_tdata,
    // [2:0] action
    input  logic [2:0]  i_s_axis_tuser,
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] current_mode, [33:2] time_to_show, [34] dot_on, [35] display_blank,
    // [36] display_refresh, [37] short_beep, [38] long_beep, [39] encoder_clear
    output logic [39:0] o_m_axis_tdata
);

    stc_pkg::t_item   in_item;
    stc_pkg::t_item   held_item;
    stc_pkg::t_result eng_result;
    stc_pkg::t_result out_result;
    logic             held_valid;
    logic             out_free;
    logic             fire;

    // unpack slave tdata/tuser; padding bits are ignored
    always_comb begin
        in_item.action              = i_s_axis_tuser;
        in_item.quarter_count       = i_s_axis_tdata[30:0];
        in_item.half_second_flag    = i_s_axis_tdata[31];
        in_item.quarter_second_flag = i_s_axis_tdata[32];
        in_item.whole_second_flag   = i_s_axis_tdata[33];
        in_item.encoder_count       = i_s_axis_tdata[49:34];
    end

    // process the held item whenever the result register can take its result
    assign fire = held_valid && out_free;

    stc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    stc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_result (eng_result)
    );

    stc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (eng_result),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result)
    );

    // pack the result, highest field first
    assign o_m_axis_tdata = {out_result.encoder_clear,
                             out_result.long_beep,
                             out_result.short_beep,
                             out_result.display_refresh,
                             out_result.display_blank,
                             out_result.dot_on,
                             out_result.time_to_show,
                             out_result.current_mode};

endmodule

// ===== hw/rtl/stc_checker.sv =====
// Port-level checks for the stopwatch / countdown timer core, bound to the top.
// Depends on stc_pkg (mode codes and master tdata bit positions).
module stc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata
);

    logic [1:0] mode;
    assign mode = o_m_axis_tdata[stc_pkg::OUT_MODE_LO +: 2];

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // reset drains the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // alarm beep always lands in stopped mode
    a_lbeep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[stc_pkg::OUT_LBEEP] |->
            mode == stc_pkg::MODE_STOPPED)
        else $error("long beep outside stopped mode");

    // blanking only in stopped mode
    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[stc_pkg::OUT_BLANK] |->
            mode == stc_pkg::MODE_STOPPED)
        else $error("blank outside stopped mode");

    // encoder clear only comes with a return to or stay in select mode
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[stc_pkg::OUT_ENCCLR] |->
            mode == stc_pkg::MODE_SELECT)
        else $error("encoder clear outside select mode");

endmodule

bind stopwatch_countdown_timer_core stc_checker u_stc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/sv/stc_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the stopwatch / countdown timer core: watches both stream channels,
// predicts each display result from the accepted items and compares field by field.
// Depends on stc_pkg for action codes, modes, the result layout and tdata offsets.
module stc_result_checker
    import stc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    // [30:0] quarter_count, [31] half, [32] quarter, [33] whole, [49:34] encoder_count
    input  logic [55:0] i_in_tdata,
    // [2:0] action
    input  logic [2:0]  i_in_tuser,
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    // [1:0] mode, [33:2] time_to_show, [34] dot, [35] blank, [36] refresh,
    // [37] short beep, [38] long beep, [39] encoder clear
    input  logic [39:0] i_out_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SECS_PER_MIN     = 60;
    localparam int QUARTERS_PER_SEC = 4;
    localparam int STEP_SECS [3]    = '{60, 10, 1};

    // predicted timer state
    t_mode       mode_q;
    logic        blink_q;
    int          elapsed_secs;
    logic [31:0] start_pt;
    logic [30:0] pause_pt;
    logic        dot_q;
    logic [1:0]  step_idx;
    int          last_scaled;
    int          alarm_secs;

    t_result display_expected[$];
    int      fails = 0;
    int      results_seen = 0;

    function automatic int shown_seconds();
        return (alarm_secs == 0) ? elapsed_secs : alarm_secs - elapsed_secs;
    endfunction

    function automatic void clear_run_time();
        elapsed_secs = 0;
        start_pt     = '0;
        pause_pt     = '0;
    endfunction

    // stop/reset: drop time, alarm and encoder scaling, back to select
    function automatic void full_clear();
        clear_run_time();
        step_idx    = '0;
        last_scaled = 0;
        alarm_secs  = 0;
        mode_q      = MODE_SELECT;
    endfunction

    function automatic t_result predict_display(input logic [2:0] act, input logic [30:0] q,
                                                input logic half, input logic quarter,
                                                input logic whole,
                                                input logic signed [15:0] enc);
        t_result     r;
        logic [31:0] diff;
        logic [31:0] mag;
        int          scale;
        int          scaled;
        int          t;
        int          show;
        logic        captured;
        logic        dot;
        logic        blank;
        logic        refresh;
        logic        sbeep;
        logic        lbeep;
        logic        clr;
        refresh  = 1'b0;
        sbeep    = 1'b0;
        lbeep    = 1'b0;
        clr      = 1'b0;
        captured = 1'b0;
        show     = 0;
        dot      = 1'b0;
        blank    = 1'b0;
        case (act)
            ACT_TICK: begin
                if (mode_q == MODE_RUNNING) begin
                    // 32-bit wrapped difference, divided toward zero
                    diff = {1'b0, q} - start_pt;
                    if (diff[31]) begin
                        mag = ~diff + 32'd1;
                        elapsed_secs = -int'(mag / 32'(QUARTERS_PER_SEC));
                    end else begin
                        elapsed_secs = int'(diff / 32'(QUARTERS_PER_SEC));
                    end
                end
                if (mode_q != MODE_RUNNING)
                    dot_q = 1'b1;
                else if (half)
                    dot_q = ~dot_q;
                if (mode_q == MODE_STOPPED && half)
                    blink_q = ~blink_q;
                refresh  = quarter;
                show     = shown_seconds();
                dot      = dot_q;
                blank    = blink_q && (mode_q == MODE_STOPPED);
                captured = 1'b1;
                if (mode_q == MODE_RUNNING) begin
                    if (elapsed_secs > 0 && (elapsed_secs % SECS_PER_MIN) > int'(BEEP_AFTER)
                        && whole)
                        sbeep = 1'b1;
                    if (alarm_secs != 0 && elapsed_secs >= alarm_secs) begin
                        mode_q = MODE_STOPPED;
                        lbeep  = 1'b1;
                    end
                end
            end
            ACT_START: begin
                case (mode_q)
                    MODE_SELECT: begin
                        clear_run_time();
                        mode_q   = MODE_RUNNING;
                        start_pt = {1'b0, q};
                    end
                    MODE_RUNNING: begin
                        mode_q   = MODE_PAUSED;
                        pause_pt = q;
                    end
                    MODE_PAUSED: begin
                        mode_q   = MODE_RUNNING;
                        start_pt = start_pt + {1'b0, q} - {1'b0, pause_pt};
                    end
                    default: begin
                        full_clear();
                        clr = 1'b1;
                    end
                endcase
            end
            ACT_STOP: begin
                if (mode_q == MODE_RUNNING || mode_q == MODE_PAUSED) begin
                    mode_q = MODE_STOPPED;
                end else begin
                    full_clear();
                    clr = 1'b1;
                end
            end
            ACT_PRECISION: begin
                if (mode_q == MODE_SELECT) begin
                    step_idx    = (step_idx >= 2'd2) ? 2'd0 : step_idx + 2'd1;
                    last_scaled = 0;
                    clr         = 1'b1;
                end else if (mode_q == MODE_STOPPED) begin
                    full_clear();
                    clr = 1'b1;
                end
            end
            ACT_ENCODER: begin
                if (mode_q == MODE_SELECT || mode_q == MODE_STOPPED) begin
                    scale  = (step_idx < 2'd3) ? STEP_SECS[step_idx] : 1;
                    scaled = int'(enc) * scale;
                    if (scaled != last_scaled) begin
                        if (mode_q == MODE_STOPPED) begin
                            full_clear();
                            clr = 1'b1;
                        end else begin
                            t = alarm_secs + (scaled - last_scaled);
                            last_scaled = scaled;
                            if (t < 0)
                                t = 0;
                            if (t > int'(ALARM_MAX))
                                t = int'(ALARM_MAX);
                            alarm_secs = t;
                            dot_q      = 1'b1;
                            refresh    = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (!captured) begin
            show  = shown_seconds();
            dot   = dot_q;
            blank = blink_q && (mode_q == MODE_STOPPED);
        end
        r.current_mode    = mode_q;
        r.time_to_show    = show;
        r.dot_on          = dot;
        r.display_blank   = blank;
        r.display_refresh = refresh;
        r.short_beep      = sbeep;
        r.long_beep       = lbeep;
        r.encoder_clear   = clr;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fails++;
        $display("[%0t] result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_result want;
        if (!i_rst_n) begin
            full_clear();
            blink_q = 1'b0;
            dot_q   = 1'b1;
            display_expected.delete();
        end else begin
            // compare first: a result never belongs to the item taken at the same edge
            if (i_out_tvalid && i_out_tready) begin
                if (display_expected.size() == 0) begin
                    report_mismatch("result with no item waiting");
                end else begin
                    want = display_expected.pop_front();
                    check_field("mode", i_out_tdata[OUT_MODE_LO +: 2], want.current_mode);
                    check_field("time_to_show", i_out_tdata[OUT_TIME_LO +: 32],
                                want.time_to_show);
                    check_field("dot_on", i_out_tdata[OUT_DOT], want.dot_on);
                    check_field("display_blank", i_out_tdata[OUT_BLANK], want.display_blank);
                    check_field("display_refresh", i_out_tdata[OUT_REFRESH],
                                want.display_refresh);
                    check_field("short_beep", i_out_tdata[OUT_SBEEP], want.short_beep);
                    check_field("long_beep", i_out_tdata[OUT_LBEEP], want.long_beep);
                    check_field("encoder_clear", i_out_tdata[OUT_ENCCLR], want.encoder_clear);
                end
                results_seen++;
            end
            if (i_in_tvalid && i_in_tready)
                display_expected.push_back(predict_display(i_in_tuser, i_in_tdata[30:0],
                    i_in_tdata[31], i_in_tdata[32], i_in_tdata[33],
                    $signed(i_in_tdata[49:34])));
        end
        o_pending    = display_expected.size();
        o_fail_count = fails;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the stopwatch / countdown timer testbench: clock, reset, item stimulus and verdict.
// Depends on stc_pkg, stopwatch_countdown_timer_core and stc_result_checker.
module testbench;
    import stc_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake on either side
    localparam int IDLE_PCT     = 9;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int          fail_count;
    int          pending;
    int          sent = 0;
    int          stall_cycles = 0;
    bit          quiet = 1'b0;        // set: neither side idles
    logic [30:0] cur_q = '0;          // system quarter-second count as the sender sees it
    logic [15:0] cur_enc = '0;        // encoder count as the sender sees it

    stopwatch_countdown_timer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    stc_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_tvalid),
        .i_in_tready  (s_tready),
        .i_in_tdata   (s_tdata),
        .i_in_tuser   (s_tuser),
        .i_out_tvalid (m_tvalid),
        .i_out_tready (m_tready),
        .i_out_tdata  (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: stall at random except in the quiet stretch.
    always @(negedge i_clk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(1));
    endfunction

    // Present one item at the falling edge and hold it until accepted; optionally
    // idle the sender first. Return at the falling edge after acceptance.
    task automatic send_item(input logic [2:0] act, input logic [30:0] q, input logic half,
                             input logic quarter, input logic whole, input logic [15:0] enc);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'd0, enc, whole, quarter, half, q};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // Advance the quarter count and send a tick with random boundary flags.
    task automatic send_tick(input int adv);
        cur_q = cur_q + 31'(adv);
        send_item(ACT_TICK, cur_q, coin(), coin(), coin(), 16'($urandom));
    endtask

    // Buttons carry random filler in the fields they do not use.
    task automatic send_button(input logic [2:0] act);
        send_item(act, cur_q, coin(), coin(), coin(), 16'($urandom));
    endtask

    // Turn the encoder by a few steps, or jump to any count now and then.
    task automatic send_encoder();
        if ($urandom_range(19) == 0)
            cur_enc = 16'($urandom);
        else
            cur_enc = cur_enc + 16'($urandom_range(0, 6)) - 16'd3;
        send_item(ACT_ENCODER, cur_q, coin(), coin(), coin(), cur_enc);
    endtask

    // One use of the watch: set an alarm in select mode, run with pauses, maybe stop,
    // blink a little, then leave through a button or the encoder and reset.
    task automatic run_session();
        int k;
        if ($urandom_range(3) == 0)
            cur_enc = '0;
        repeat ($urandom_range(0, 6)) begin
            k = $urandom_range(9);
            if (k < 2)
                send_button(ACT_PRECISION);
            else if (k == 2)
                send_tick($urandom_range(0, 3));
            else
                send_encoder();
        end
        send_button(ACT_START);
        repeat ($urandom_range(5, 70)) begin
            k = $urandom_range(99);
            if (k < 5) begin
                send_tick($urandom_range(40, 400));
            end else if (k < 11) begin
                send_button(ACT_START);
            end else if (k < 14) begin
                // buttons and codes that a running watch ignores
                send_item(3'($urandom_range(3, 7)), cur_q, coin(), coin(), coin(),
                          16'($urandom));
            end else if (k == 14) begin
                // wild jump of the system count, possibly behind the start point
                cur_q = 31'($urandom);
                send_tick(0);
            end else begin
                send_tick($urandom_range(0, 12));
            end
        end
        if (coin())
            send_button(ACT_STOP);
        repeat ($urandom_range(1, 4)) send_tick($urandom_range(0, 3));
        k = $urandom_range(2);
        if (k == 0)
            send_button(ACT_START);
        else if (k == 1)
            send_button(ACT_PRECISION);
        else
            send_encoder();
        send_button(ACT_STOP);
        send_button(ACT_STOP);
    endtask

    initial begin
        bit drained;
        drained = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: encoder extremes and clamping in select mode.
        send_item(ACT_TICK, 31'd0, 1'b1, 1'b1, 1'b1, 16'h0000);
        send_item(ACT_ENCODER, 31'd0, 1'b0, 1'b0, 1'b0, 16'h0001);
        send_item(ACT_ENCODER, 31'd0, 1'b1, 1'b1, 1'b1, 16'h7fff);   // clamp high
        send_item(ACT_ENCODER, 31'd0, 1'b0, 1'b0, 1'b0, 16'h8000);   // clamp low
        send_item(ACT_ENCODER, 31'd0, 1'b0, 1'b0, 1'b0, 16'h8000);   // no change
        send_item(ACT_PRECISION, 31'd0, 1'b0, 1'b0, 1'b0, 16'h0000); // 10 s steps
        send_item(ACT_ENCODER, 31'd0, 1'b0, 1'b0, 1'b0, 16'h0002);   // alarm 20 s
        send_item(ACT_PRECISION, 31'd0, 1'b0, 1'b0, 1'b0, 16'h0000); // 1 s steps
        // unused action code with every field bit high
        send_item(3'd5, 31'h7fffffff, 1'b1, 1'b1, 1'b1, 16'hffff);
        // Run into the alarm: long beep and stop on the tick that reaches it.
        send_item(ACT_START, 31'd1000, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_item(ACT_TICK, 31'd1040, 1'b1, 1'b0, 1'b1, 16'h0000);
        send_item(ACT_TICK, 31'd1079, 1'b0, 1'b1, 1'b1, 16'h0000);
        send_item(ACT_TICK, 31'd1080, 1'b0, 1'b1, 1'b1, 16'h0000);
        send_item(ACT_TICK, 31'd1081, 1'b1, 1'b1, 1'b0, 16'h0000);   // blank in stopped
        send_item(ACT_ENCODER, 31'd1081, 1'b0, 1'b0, 1'b0, 16'h0007); // reset from stopped
        // Short beep near the top of the count, then a count behind the start point.
        send_item(ACT_START, 31'h7fffff00, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_item(ACT_TICK, 31'h7fffffdc, 1'b0, 1'b1, 1'b1, 16'h0000);
        send_item(ACT_TICK, 31'd0, 1'b1, 1'b1, 1'b1, 16'h0000);
        // Pause and resume across the wrap of the start point.
        send_item(ACT_START, 31'h7fffffff, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_item(ACT_TICK, 31'd7, 1'b1, 1'b0, 1'b0, 16'h0000);
        send_item(ACT_START, 31'd5, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_item(ACT_TICK, 31'd100, 1'b0, 1'b1, 1'b1, 16'h0000);
        send_item(ACT_STOP, 31'd100, 1'b0, 1'b0, 1'b0, 16'h0000);
        send_item(ACT_START, 31'd100, 1'b0, 1'b0, 1'b0, 16'h0000);   // reset from stopped
        send_item(ACT_STOP, 31'd100, 1'b0, 1'b0, 1'b0, 16'h0000);    // reset in select
        send_item(3'd7, 31'd0, 1'b0, 1'b0, 1'b0, 16'h0000);

        // Random: mostly well-formed sessions, with bursts of raw noise in between.
        cur_q = 31'($urandom);
        while (sent < RANDOM_ITEMS + 26) begin
            // hold off once until every result is back
            if (!drained && sent > RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
                drained = 1'b1;
            end
            quiet = (sent >= 500 && sent < 650);
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(5, 20))
                    send_item(3'($urandom_range(7)), 31'($urandom), coin(), coin(), coin(),
                              16'($urandom));
            end else begin
                run_session();
            end
        end

        // Drain: drop valid, wait for the last results, then let the pipeline settle.
        s_tvalid <= 1'b0;
        quiet = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/stc_pkg.sv
hw/rtl/stc_in_stage.sv
hw/rtl/stc_engine.sv
hw/rtl/stc_out_stage.sv
hw/rtl/stopwatch_countdown_timer_core.sv
hw/rtl/stc_checker.sv
tb/sv/stc_result_checker.sv
tb/sv/testbench.sv
